>>> sv/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the console line editor with history ring.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int LINE_BYTES  = 64;
    localparam int LINE_W      = $clog2(LINE_BYTES);
    localparam int HIST_DEPTH  = 32;
    localparam int SLOT_W      = $clog2(HIST_DEPTH);
    localparam int COUNT_W     = $clog2(HIST_DEPTH + 1);
    localparam int HIST_ADDR_W = SLOT_W + LINE_W;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_CTRL_U = 8'h15;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_LEFT   = 8'h44;

    typedef enum logic [1:0] {
        ACT_ECHO    = 2'd0,
        ACT_ERASE   = 2'd1,
        ACT_NEWLINE = 2'd2,
        ACT_LINE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAVE,
        ST_RECALL
    } state_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  char_out;
        logic [5:0]  erase_count;
        logic        last;
    } result_t;

endpackage

>>> sv/serial_line_editor_with_history_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor_with_history_core
// Console line editor: edits a line buffer from received bytes, echoes,
// emits completed lines and keeps a ring of recent lines for recall.
//
//   channel  signals                                   direction
//   in       in_valid, in_stall, rx_byte               request in
//   out      out_valid, out_stall, action, char_out,   request out
//            erase_count, last
//
// Plain edit bytes are handled on acceptance. Enter or a recall sends the n
// line bytes (up to 63) one result per cycle while out_stall is low, paced by
// the line buffer and history ram read ports. A new byte is taken once the last
// result has left, at the earliest in the cycle it leaves. Reset clears control
// state and the history lengths at once; no clearing pass. out_stall holds
// results and, through them, the ram reads.
// ----------------------------------------------------------------------------
module serial_line_editor_with_history_core
    import sle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [7:0]  char_out,
    output logic [5:0]  erase_count,
    output logic        last
);

    state_t              state_reg, state_next;
    logic [LINE_W-1:0]   line_length_reg, line_length_next;
    logic [SLOT_W-1:0]   save_slot_reg, save_slot_next;
    logic [COUNT_W-1:0]  saved_count_reg, saved_count_next;
    logic [SLOT_W-1:0]   shown_slot_reg, shown_slot_next;
    logic                bracket_reg, bracket_next;
    logic [SLOT_W-1:0]   work_slot_reg, work_slot_next;
    logic [LINE_W-1:0]   work_len_reg, work_len_next;
    logic [LINE_W-1:0]   idx_reg, idx_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                rd_save_reg, rd_save_next;
    logic                rd_last_reg, rd_last_next;
    logic [LINE_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                out_valid_reg, out_valid_next;
    result_t             res_reg, res_next;
    logic [LINE_W-1:0]   hist_len_reg [HIST_DEPTH];

    logic                hl_we;
    logic [SLOT_W-1:0]   hl_idx;
    logic [LINE_W-1:0]   hl_data;

    logic                lb_we, lb_re;
    logic [LINE_W-1:0]   lb_waddr, lb_raddr;
    logic [7:0]          lb_wdata, lb_rdata;
    logic                hs_we, hs_re;
    logic [HIST_ADDR_W-1:0] hs_waddr, hs_raddr;
    logic [7:0]          hs_rdata;

    logic                out_free, accept, rd_free, issue, move;
    logic [SLOT_W-1:0]   slot_sel;
    logic [LINE_W-1:0]   recall_len;
    logic [7:0]          rd_data;

    sle_ram #(.ADDR_W(LINE_W), .DATA_W(8)) u_line_ram (
        .clk   (clk),
        .we    (lb_we),
        .waddr (lb_waddr),
        .wdata (lb_wdata),
        .re    (lb_re),
        .raddr (lb_raddr),
        .rdata (lb_rdata)
    );

    sle_ram #(.ADDR_W(HIST_ADDR_W), .DATA_W(8)) u_hist_ram (
        .clk   (clk),
        .we    (hs_we),
        .waddr (hs_waddr),
        .wdata (lb_rdata),
        .re    (hs_re),
        .raddr (hs_raddr),
        .rdata (hs_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && !rd_valid_reg && out_free);
    assign accept   = in_valid && !in_stall;
    assign move     = rd_valid_reg && out_free;
    assign rd_free  = !rd_valid_reg || out_free;
    assign issue    = (state_reg != ST_IDLE) && rd_free;
    assign rd_data  = rd_save_reg ? lb_rdata : hs_rdata;

    // arrow keys move the shown slot before recall
    always_comb
    begin
        slot_sel = shown_slot_reg;
        if (rx_byte == CH_UP)
        begin
            if ((shown_slot_reg != '0) && (COUNT_W'(shown_slot_reg) < saved_count_reg))
            begin
                slot_sel = shown_slot_reg - SLOT_W'(1);
            end
        end
        else if (rx_byte == CH_DOWN)
        begin
            if ((COUNT_W'(shown_slot_reg) + COUNT_W'(1)) < saved_count_reg)
            begin
                slot_sel = shown_slot_reg + SLOT_W'(1);
            end
        end
        recall_len = hist_len_reg[slot_sel];
    end

    always_comb
    begin
        state_next       = state_reg;
        line_length_next = line_length_reg;
        save_slot_next   = save_slot_reg;
        saved_count_next = saved_count_reg;
        shown_slot_next  = shown_slot_reg;
        bracket_next     = bracket_reg;
        work_slot_next   = work_slot_reg;
        work_len_next    = work_len_reg;
        idx_next         = idx_reg;
        rd_valid_next    = rd_valid_reg;
        rd_save_next     = rd_save_reg;
        rd_last_next     = rd_last_reg;
        rd_idx_next      = rd_idx_reg;
        out_valid_next   = out_valid_reg && out_stall;
        res_next         = res_reg;
        hl_we            = 1'b0;
        hl_idx           = save_slot_reg;
        hl_data          = line_length_reg;
        lb_we            = 1'b0;
        lb_waddr         = line_length_reg;
        lb_wdata         = rx_byte;
        lb_re            = 1'b0;
        lb_raddr         = idx_reg;
        hs_we            = 1'b0;
        hs_waddr         = {work_slot_reg, rd_idx_reg};
        hs_re            = 1'b0;
        hs_raddr         = {work_slot_reg, idx_reg};

        // pending ram read goes to the output register and into the other ram
        if (move)
        begin
            out_valid_next       = 1'b1;
            res_next.action      = rd_save_reg ? ACT_LINE : ACT_ECHO;
            res_next.char_out    = rd_data;
            res_next.erase_count = '0;
            res_next.last        = rd_last_reg;
            rd_valid_next        = 1'b0;
            if (rd_save_reg)
            begin
                hs_we = 1'b1;
            end
            else
            begin
                lb_we    = 1'b1;
                lb_waddr = rd_idx_reg;
                lb_wdata = hs_rdata;
            end
        end

        if (issue)
        begin
            rd_valid_next = 1'b1;
            rd_save_next  = (state_reg == ST_SAVE);
            rd_idx_next   = idx_reg;
            rd_last_next  = (idx_reg == work_len_reg - LINE_W'(1));
            lb_re         = (state_reg == ST_SAVE);
            hs_re         = (state_reg == ST_RECALL);
            idx_next      = idx_reg + LINE_W'(1);
            if (idx_reg == work_len_reg - LINE_W'(1))
            begin
                state_next = ST_IDLE;
            end
        end

        if (accept)
        begin
            res_next.char_out    = '0;
            res_next.erase_count = '0;
            res_next.last        = 1'b1;
            idx_next             = '0;
            priority if (bracket_reg)
            begin
                bracket_next = 1'b0;
                if ((rx_byte >= CH_UP) && (rx_byte <= CH_LEFT))
                begin
                    shown_slot_next = slot_sel;
                    work_slot_next  = slot_sel;
                    work_len_next   = recall_len;
                    if (line_length_reg != '0)
                    begin
                        out_valid_next       = 1'b1;
                        res_next.action      = ACT_ERASE;
                        res_next.erase_count = 6'(line_length_reg);
                        res_next.last        = (recall_len == '0);
                    end
                    line_length_next = recall_len;
                    if (recall_len != '0)
                    begin
                        state_next = ST_RECALL;
                    end
                end
            end
            else if (rx_byte == CH_BS)
            begin
                if (line_length_reg != '0)
                begin
                    line_length_next     = line_length_reg - LINE_W'(1);
                    out_valid_next       = 1'b1;
                    res_next.action      = ACT_ERASE;
                    res_next.erase_count = 6'd1;
                end
            end
            else if ((rx_byte == CH_CR) || (rx_byte == CH_LF))
            begin
                out_valid_next    = 1'b1;
                res_next.action   = ACT_NEWLINE;
                res_next.char_out = CH_LF;
                res_next.last     = (line_length_reg == '0);
                if (line_length_reg != '0)
                begin
                    hl_we            = 1'b1;
                    work_slot_next   = save_slot_reg;
                    work_len_next    = line_length_reg;
                    line_length_next = '0;
                    state_next       = ST_SAVE;
                    save_slot_next   = (save_slot_reg == SLOT_W'(HIST_DEPTH - 1)) ?
                                       '0 : save_slot_reg + SLOT_W'(1);
                    if (saved_count_reg < COUNT_W'(HIST_DEPTH))
                    begin
                        saved_count_next = saved_count_reg + COUNT_W'(1);
                    end
                end
            end
            else if ((rx_byte == CH_ESC) || (rx_byte == CH_CTRL_U))
            begin
                if (line_length_reg != '0)
                begin
                    out_valid_next       = 1'b1;
                    res_next.action      = ACT_ERASE;
                    res_next.erase_count = 6'(line_length_reg);
                end
                line_length_next = '0;
            end
            else if ((rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE) &&
                     (line_length_reg < LINE_W'(LINE_BYTES - 1)))
            begin
                if (rx_byte == CH_LBRACK)
                begin
                    bracket_next = 1'b1;
                end
                else
                begin
                    lb_we             = 1'b1;
                    line_length_next  = line_length_reg + LINE_W'(1);
                    out_valid_next    = 1'b1;
                    res_next.action   = ACT_ECHO;
                    res_next.char_out = rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            line_length_reg <= '0;
            save_slot_reg   <= '0;
            saved_count_reg <= '0;
            shown_slot_reg  <= '0;
            bracket_reg     <= 1'b0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            line_length_reg <= line_length_next;
            save_slot_reg   <= save_slot_next;
            saved_count_reg <= saved_count_next;
            shown_slot_reg  <= shown_slot_next;
            bracket_reg     <= bracket_next;
            rd_valid_reg    <= rd_valid_next;
            out_valid_reg   <= out_valid_next;
            if (hl_we)
            begin
                hist_len_reg[hl_idx] <= hl_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_slot_reg <= work_slot_next;
        work_len_reg  <= work_len_next;
        idx_reg       <= idx_next;
        rd_save_reg   <= rd_save_next;
        rd_last_reg   <= rd_last_next;
        rd_idx_reg    <= rd_idx_next;
        res_reg       <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign action      = res_reg.action;
    assign char_out    = res_reg.char_out;
    assign erase_count = res_reg.erase_count;
    assign last        = res_reg.last;

endmodule

>>> sv/sle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
